@@ sv/iwd_pkg.sv @@
// Shared constants, helper functions and calendar tables of the ISO week date calculator.
package iwd_pkg;

  // Field widths of the request and result payloads.
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned WEEK_W  = 6;
  localparam int unsigned YDAY_W  = 9;
  localparam int unsigned MLEN_W  = 5;

  // Years are held as an offset from the first supported year.
  localparam int unsigned YOFS_W = 7;
  localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2099;

  // Month numbers that matter to the logic.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Weekday codes, Sunday first; ISO numbers Sunday as seven.
  localparam logic [WDAY_W-1:0] WD_SUN = 3'd0;
  localparam logic [WDAY_W-1:0] WD_WED = 3'd3;
  localparam logic [WDAY_W-1:0] WD_THU = 3'd4;
  localparam logic [WDAY_W-1:0] ISO_SUN = 3'd7;

  // Weekday sum of the year before the first supported year (1999).
  localparam logic [WDAY_W-1:0] WD_BASE_PREV = 3'd5;

  localparam logic [WEEK_W-1:0] WEEKS_SHORT = 6'd52;
  localparam logic [WEEK_W-1:0] WEEKS_LONG  = 6'd53;
  localparam logic [WEEK_W-1:0] WEEK_FIRST  = 6'd1;
  localparam logic [YDAY_W-1:0] ISO_BIAS    = 9'd10;

  // Division by seven through a reciprocal: floor(x / 7) = (x * M) >> S.
  // The week formula takes values up to 375, the weekday sums up to 160.
  localparam int unsigned        WK_DIV_SH  = 11;
  localparam logic [YDAY_W-1:0]  WK_DIV_MUL = 9'd293;
  localparam int unsigned        MOD_DIV_SH = 10;
  localparam logic [7:0]         MOD_DIV_MUL = 8'd147;
  localparam logic [7:0]         SEVEN = 8'd7;

  // Remainder by seven of a value up to 160.
  function automatic logic [WDAY_W-1:0] mod7(input logic [7:0] x);
    logic [15:0] p;
    logic [7:0]  q;
    begin
      p = 16'(x) * 16'(MOD_DIV_MUL);
      q = 8'(p[15:MOD_DIV_SH]);
      mod7 = WDAY_W'(x - 8'(q * SEVEN));
    end
  endfunction

  // Sakamoto month offsets.
  function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] r;
    begin
      case (m)
        4'd2:    r = 3'd3;
        4'd3:    r = 3'd2;
        4'd4:    r = 3'd5;
        4'd5:    r = 3'd0;
        4'd6:    r = 3'd3;
        4'd7:    r = 3'd5;
        4'd8:    r = 3'd1;
        4'd9:    r = 3'd4;
        4'd10:   r = 3'd6;
        4'd11:   r = 3'd2;
        4'd12:   r = 3'd4;
        default: r = 3'd0;
      endcase
      month_offset = r;
    end
  endfunction

  // Days in a month of a common year; zero for a month that does not exist.
  function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] r;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
        4'd2:                                       r = 5'd28;
        default:                                    r = 5'd0;
      endcase
      month_days = r;
    end
  endfunction

  // Days of a common year before the first of the month.
  function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] r;
    begin
      case (m)
        4'd2:    r = 9'd31;
        4'd3:    r = 9'd59;
        4'd4:    r = 9'd90;
        4'd5:    r = 9'd120;
        4'd6:    r = 9'd151;
        4'd7:    r = 9'd181;
        4'd8:    r = 9'd212;
        4'd9:    r = 9'd243;
        4'd10:   r = 9'd273;
        4'd11:   r = 9'd304;
        4'd12:   r = 9'd334;
        default: r = 9'd0;
      endcase
      days_before = r;
    end
  endfunction

endpackage

@@ sv/iwd_req_if.sv @@
// Request channel carrying one Gregorian date.
interface iwd_req_if;
  import iwd_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink   (input valid, input year, input month, input day, output ready);
endinterface

@@ sv/iwd_res_if.sv @@
// Result channel carrying the calendar facts of one date.
interface iwd_res_if;
  import iwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [WDAY_W-1:0] weekday;
  logic [WEEK_W-1:0] iso_week;
  logic [YDAY_W-1:0] year_day;
  logic [MLEN_W-1:0] month_length;
  logic              leap;

  modport source (output valid, output valid_res, output weekday, output iso_week,
                  output year_day, output month_length, output leap, input ready);
  modport sink   (input valid, input valid_res, input weekday, input iso_week,
                  input year_day, input month_length, input leap, output ready);
endinterface

@@ sv/iso_week_date_calculator_unit.sv @@
// Top level of the ISO week date calculator: a five-stage date pipeline.
//
// Each request carries a Gregorian date and yields exactly one result from
// the last register stage. While the result channel is not stalled, a new
// request can be taken in every cycle; the throughput is one date per
// clock, set by the register stages, each holding about one small constant
// multiply or add. Years below 2000 are treated as 2000 and years above 2099
// as 2099. A month outside 1 to 12 or a day outside the month's length gives
// valid_res low with every other result field zero. Weekdays run from 0
// (Sunday) to 6 (Saturday); the ISO week wraps to 52 or 53 of the previous
// year before week one, and to week 1 after the last week of the year.
// Every stage has its own valid bit and stalls only when the stage after it
// is full and blocked, so bubbles are squeezed out and a stalled result
// never blocks requests while free stages remain.
module iso_week_date_calculator_unit
  import iwd_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  iwd_req_if.sink      in_req,
  iwd_res_if.source    out_res
);

  // Stage 1: year offset, leap flag, month length and range check.
  typedef struct packed {
    logic [YOFS_W-1:0]  yofs;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               leap;
    logic [MLEN_W-1:0]  mlen;
    logic               ok;
  } s1_t;

  // Stage 2: unreduced weekday sums and the day of year.
  typedef struct packed {
    logic               ok;
    logic               leap;
    logic [MLEN_W-1:0]  mlen;
    logic [7:0]         wd_sum;
    logic [YDAY_W-1:0]  yday;
    logic [7:0]         jan_sum;
    logic [7:0]         jan_prev_sum;
    logic               first_year;
    logic               leap_prev;
  } s2_t;

  // Stage 3: weekday and week counts of this and the previous year.
  typedef struct packed {
    logic               ok;
    logic               leap;
    logic [MLEN_W-1:0]  mlen;
    logic [WDAY_W-1:0]  wday;
    logic [YDAY_W-1:0]  yday;
    logic               long_year;
    logic               long_prev;
  } s3_t;

  // Stage 4: raw ISO week before wrapping.
  typedef struct packed {
    logic               ok;
    logic               leap;
    logic [MLEN_W-1:0]  mlen;
    logic [WDAY_W-1:0]  wday;
    logic [YDAY_W-1:0]  yday;
    logic               long_year;
    logic               long_prev;
    logic [WEEK_W-1:0]  week_raw;
  } s4_t;

  typedef struct packed {
    logic               valid_res;
    logic [WDAY_W-1:0]  weekday;
    logic [WEEK_W-1:0]  iso_week;
    logic [YDAY_W-1:0]  year_day;
    logic [MLEN_W-1:0]  month_length;
    logic               leap;
  } res_t;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  res_t out_r, out_nxt;

  // A stage can load when it is empty or its content moves on this cycle.
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  assign rdy_out = !out_vld_r || out_res.ready;
  assign rdy4    = !s4_vld_r || rdy_out;
  assign rdy3    = !s3_vld_r || rdy4;
  assign rdy2    = !s2_vld_r || rdy3;
  assign rdy1    = !s1_vld_r || rdy2;
  assign in_req.ready = rdy1;

  // Stage 1 logic: clamp the year and check the date against its month.
  logic [YEAR_W-1:0] year_diff;
  logic              month_ok;

  always_comb begin
    year_diff = in_req.year - YEAR_MIN;
    if (in_req.year < YEAR_MIN) begin
      s1_nxt.yofs = '0;
    end else if (in_req.year > YEAR_MAX) begin
      s1_nxt.yofs = YOFS_W'(YEAR_MAX - YEAR_MIN);
    end else begin
      s1_nxt.yofs = YOFS_W'(year_diff);
    end
    // Within 2000 to 2099 every fourth year is a leap year, 2000 included.
    s1_nxt.leap  = (s1_nxt.yofs[1:0] == 2'd0);
    s1_nxt.month = in_req.month;
    s1_nxt.day   = in_req.day;
    month_ok     = (in_req.month >= MONTH_JAN) && (in_req.month <= MONTH_DEC);
    s1_nxt.mlen  = month_days(in_req.month) +
                   MLEN_W'((in_req.month == MONTH_FEB) && s1_nxt.leap);
    s1_nxt.ok    = month_ok && (in_req.day != '0) && (in_req.day <= s1_nxt.mlen);
  end

  // Stage 2 logic: Sakamoto sums. With the year written as 2000 + k the
  // century terms cancel modulo seven, so the sum is k + k/4; the year
  // before 2000 contributes a fixed five.
  logic              early;
  logic [YOFS_W-1:0] k_wd, k_jan, k_prev;

  always_comb begin
    early  = (s1_r.month < MONTH_MAR);
    k_wd   = s1_r.yofs - YOFS_W'(early);
    k_jan  = s1_r.yofs - YOFS_W'(1);
    k_prev = s1_r.yofs - YOFS_W'(2);

    if (s1_r.yofs == '0 && early) begin
      s2_nxt.wd_sum = 8'(WD_BASE_PREV);
    end else begin
      s2_nxt.wd_sum = 8'(k_wd) + 8'(k_wd >> 2);
    end
    s2_nxt.wd_sum = s2_nxt.wd_sum + 8'(month_offset(s1_r.month)) + 8'(s1_r.day);

    // First of January of this year, then of the year before.
    if (s1_r.yofs == '0) begin
      s2_nxt.jan_sum = 8'(WD_BASE_PREV) + 8'd1;
    end else begin
      s2_nxt.jan_sum = 8'(k_jan) + 8'(k_jan >> 2) + 8'd1;
    end
    if (s1_r.yofs == YOFS_W'(1)) begin
      s2_nxt.jan_prev_sum = 8'(WD_BASE_PREV) + 8'd1;
    end else begin
      s2_nxt.jan_prev_sum = 8'(k_prev) + 8'(k_prev >> 2) + 8'd1;
    end
    // 1999 has 52 weeks; it is handled by this flag alone.
    s2_nxt.first_year = (s1_r.yofs == '0);
    s2_nxt.leap_prev  = (s1_r.yofs != '0) && (k_jan[1:0] == 2'd0);

    s2_nxt.yday = days_before(s1_r.month) + YDAY_W'(s1_r.day) +
                  YDAY_W'(s1_r.leap && (s1_r.month > MONTH_FEB));
    s2_nxt.ok   = s1_r.ok;
    s2_nxt.leap = s1_r.leap;
    s2_nxt.mlen = s1_r.mlen;
  end

  // Stage 3 logic: reduce the sums modulo seven and find the week counts.
  logic [WDAY_W-1:0] jan_wd, jan_prev_wd;

  always_comb begin
    jan_wd      = mod7(s2_r.jan_sum);
    jan_prev_wd = mod7(s2_r.jan_prev_sum);
    s3_nxt.wday = mod7(s2_r.wd_sum);
    // A year has 53 weeks when it opens on a Thursday, or on a Wednesday
    // in a leap year.
    s3_nxt.long_year = (jan_wd == WD_THU) || ((jan_wd == WD_WED) && s2_r.leap);
    s3_nxt.long_prev = !s2_r.first_year &&
                       ((jan_prev_wd == WD_THU) ||
                        ((jan_prev_wd == WD_WED) && s2_r.leap_prev));
    s3_nxt.yday = s2_r.yday;
    s3_nxt.ok   = s2_r.ok;
    s3_nxt.leap = s2_r.leap;
    s3_nxt.mlen = s2_r.mlen;
  end

  // Stage 4 logic: (year_day + 10 - iso_weekday) / 7 by reciprocal.
  logic [WDAY_W-1:0]   iso_wd;
  logic [YDAY_W-1:0]   week_num;
  logic [2*YDAY_W-1:0] week_prod;

  always_comb begin
    iso_wd    = (s3_r.wday == WD_SUN) ? ISO_SUN : s3_r.wday;
    week_num  = s3_r.yday + ISO_BIAS - YDAY_W'(iso_wd);
    week_prod = (2*YDAY_W)'(week_num) * (2*YDAY_W)'(WK_DIV_MUL);
    s4_nxt.week_raw  = WEEK_W'(week_prod >> WK_DIV_SH);
    s4_nxt.ok        = s3_r.ok;
    s4_nxt.leap      = s3_r.leap;
    s4_nxt.mlen      = s3_r.mlen;
    s4_nxt.wday      = s3_r.wday;
    s4_nxt.yday      = s3_r.yday;
    s4_nxt.long_year = s3_r.long_year;
    s4_nxt.long_prev = s3_r.long_prev;
  end

  // Stage 5 logic: wrap the week into the neighboring years and clear the
  // fields of an invalid date.
  logic [WEEK_W-1:0] weeks_this, weeks_prev, week_fix;

  always_comb begin
    weeks_this = s4_r.long_year ? WEEKS_LONG : WEEKS_SHORT;
    weeks_prev = s4_r.long_prev ? WEEKS_LONG : WEEKS_SHORT;
    if (s4_r.week_raw == '0) begin
      week_fix = weeks_prev;
    end else if (s4_r.week_raw > weeks_this) begin
      week_fix = WEEK_FIRST;
    end else begin
      week_fix = s4_r.week_raw;
    end
    if (s4_r.ok) begin
      out_nxt.valid_res    = 1'b1;
      out_nxt.weekday      = s4_r.wday;
      out_nxt.iso_week     = week_fix;
      out_nxt.year_day     = s4_r.yday;
      out_nxt.month_length = s4_r.mlen;
      out_nxt.leap         = s4_r.leap;
    end else begin
      out_nxt = '0;
    end
  end

  // Valid bits are cleared by reset; payload registers load with their stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1)    s1_vld_r  <= in_req.valid;
      if (rdy2)    s2_vld_r  <= s1_vld_r;
      if (rdy3)    s3_vld_r  <= s2_vld_r;
      if (rdy4)    s4_vld_r  <= s3_vld_r;
      if (rdy_out) out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_req.valid) s1_r  <= s1_nxt;
    if (rdy2 && s1_vld_r)     s2_r  <= s2_nxt;
    if (rdy3 && s2_vld_r)     s3_r  <= s3_nxt;
    if (rdy4 && s3_vld_r)     s4_r  <= s4_nxt;
    if (rdy_out && s4_vld_r)  out_r <= out_nxt;
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.valid_res    = out_r.valid_res;
  assign out_res.weekday      = out_r.weekday;
  assign out_res.iso_week     = out_r.iso_week;
  assign out_res.year_day     = out_r.year_day;
  assign out_res.month_length = out_r.month_length;
  assign out_res.leap         = out_r.leap;

  // An invalid date carries no calendar facts.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.valid_res) |->
      (out_res.weekday == '0 && out_res.iso_week == '0 && out_res.year_day == '0 &&
       out_res.month_length == '0 && !out_res.leap))
    else $error("invalid date result has nonzero fields");

  // A valid date has a real weekday and a week within 1 to 53.
  a_week_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.valid_res) |->
      (out_res.weekday <= 3'd6 && out_res.iso_week >= WEEK_FIRST &&
       out_res.iso_week <= WEEKS_LONG))
    else $error("weekday or ISO week out of range");

  // The day of year agrees with the leap flag and the month length is real.
  a_yday_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.valid_res) |->
      (out_res.year_day >= 9'd1 &&
       out_res.year_day <= (out_res.leap ? 9'd366 : 9'd365) &&
       out_res.month_length >= 5'd28))
    else $error("day of year or month length out of range");

  // Stage 4 never holds its item while the output stage sits empty and free.
  a_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_vld_r && !out_vld_r) |=> out_vld_r)
    else $error("pipeline held an item without a stall");

endmodule

@@ dv/iso_week_date_calculator_unit_test.sv @@
// Self-checking testbench of the ISO week date calculator unit.
module iso_week_date_calculator_unit_test;
  import iwd_pkg::*;

  // Calendar facts of one date, laid out like the result channel payload.
  typedef struct packed {
    logic              valid_res;
    logic [WDAY_W-1:0] weekday;
    logic [WEEK_W-1:0] iso_week;
    logic [YDAY_W-1:0] year_day;
    logic [MLEN_W-1:0] month_length;
    logic              leap;
  } date_facts_t;

  // The receiver's long hold-off, in clock cycles. It is far longer than the
  // pipeline depth, so the request side is sure to back up and stall.
  localparam int HOLD_CYCLES  = 200;
  // Cycles allowed after the last expected result for stray results to show.
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  logic clk;
  logic rst_n;

  iwd_req_if req_ch ();
  iwd_res_if res_ch ();

  iso_week_date_calculator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_res (res_ch.source)
  );

  // Expected facts of every accepted request, oldest first.
  date_facts_t pending_facts[$];
  int          fault_count = 0;

  // When set, neither side idles: requests go back to back and results are
  // taken unless a hold-off is pending.
  bit quiet = 1'b0;

  // The test raises hold_requests; the receiver process notices the change
  // and counts out its hold-off on its own.
  int hold_requests = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic of the predictor. All of it is done on plain integers
  // and only narrowed to the channel widths when the result is assembled.
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Length of month m (1..12) in year y.
  function automatic int month_span(input int y, input int m);
    case (m)
      int'(MONTH_FEB): return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:     return 30;
      default:         return 31;
    endcase
  endfunction

  // Month term of Sakamoto's weekday formula, January and February being
  // counted as the tail of the year before.
  function automatic int sakamoto_offset(input int m);
    case (m)
      2, 6:    return 3;
      3, 11:   return 2;
      4, 7:    return 5;
      8:       return 1;
      9, 12:   return 4;
      10:      return 6;
      default: return 0;
    endcase
  endfunction

  // Day of the week, 0 for Sunday through 6 for Saturday.
  function automatic int weekday_of(input int y, input int m, input int d);
    int a;
    a = (m < 3) ? y - 1 : y;
    return (a + a / 4 - a / 100 + a / 400 + sakamoto_offset(m) + d) % 7;
  endfunction

  // A year has 53 ISO weeks when it starts on a Thursday, or on a Wednesday
  // in a leap year; otherwise 52.
  function automatic int iso_weeks_in(input int y);
    int jan1;
    jan1 = weekday_of(y, int'(MONTH_JAN), 1);
    if (jan1 == int'(WD_THU) || (jan1 == int'(WD_WED) && leap_year(y)))
      return int'(WEEKS_LONG);
    return int'(WEEKS_SHORT);
  endfunction

  // Expected result of one request.
  function automatic date_facts_t predict_date_facts(input logic [YEAR_W-1:0]  year_in,
                                                     input logic [MONTH_W-1:0] month_in,
                                                     input logic [DAY_W-1:0]   day_in);
    date_facts_t f;
    int          y;
    int          m;
    int          d;
    int          len;
    int          wd;
    int          iso_wd;
    int          yday;
    int          wk;
    f = '0;
    // Years outside the supported century saturate to its ends.
    y = int'(year_in);
    if (y < int'(YEAR_MIN))
      y = int'(YEAR_MIN);
    if (y > int'(YEAR_MAX))
      y = int'(YEAR_MAX);
    m = int'(month_in);
    d = int'(day_in);
    // A month or day that does not exist gives an all-zero result.
    if (m < 1 || m > 12)
      return f;
    len = month_span(y, m);
    if (d < 1 || d > len)
      return f;
    wd   = weekday_of(y, m, d);
    yday = d;
    for (int k = 1; k < m; k++)
      yday += month_span(y, k);
    // ISO numbering puts Sunday last, as day seven.
    iso_wd = (wd == int'(WD_SUN)) ? int'(ISO_SUN) : wd;
    wk     = (yday + int'(ISO_BIAS) - iso_wd) / 7;
    // Days before week one belong to the last week of the previous year;
    // days after the last week belong to week one of the next year.
    if (wk < 1)
      wk = iso_weeks_in(y - 1);
    else if (wk > iso_weeks_in(y))
      wk = int'(WEEK_FIRST);
    f.valid_res    = 1'b1;
    f.weekday      = WDAY_W'(wd);
    f.iso_week     = WEEK_W'(wk);
    f.year_day     = YDAY_W'(yday);
    f.month_length = MLEN_W'(len);
    f.leap         = leap_year(y);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. The task is always entered and left at a rising edge. It
  // may idle before offering the date unless quiet is set, each cycle idling with
  // a chance of about 35 in a hundred; the date goes onto the queue of expected
  // facts in the cycle it is accepted. Valid is never lowered and raised in
  // the same step: it only drops when an idle cycle is chosen.
  // ---------------------------------------------------------------------------
  task automatic send_date(input logic [YEAR_W-1:0]  year_in,
                           input logic [MONTH_W-1:0] month_in,
                           input logic [DAY_W-1:0]   day_in);
    while (!quiet && $urandom_range(99) < 35) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.year  <= year_in;
    req_ch.month <= month_in;
    req_ch.day   <= day_in;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    pending_facts.push_back(predict_date_facts(year_in, month_in, day_in));
  endtask

  // Result side readiness. A pending hold-off request wins; otherwise the
  // receiver stalls with a chance of about 35 in a hundred unless quiet is set.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_taken != hold_requests) begin
      hold_taken   <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (quiet) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= 35);
    end
  end

  // Every accepted result is compared with the oldest expectation. A result
  // that arrives with nothing expected is a fault as well.
  always @(posedge clk) begin
    date_facts_t got;
    date_facts_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.valid_res, res_ch.weekday, res_ch.iso_week, res_ch.year_day,
              res_ch.month_length, res_ch.leap};
      if (pending_facts.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected valid_res=%0d wday=%0d week=%0d yday=%0d mlen=%0d leap=%0d",
                   got.valid_res, got.weekday, got.iso_week, got.year_day,
                   got.month_length, got.leap);
      end else begin
        want = pending_facts.pop_front();
        if (got.valid_res !== want.valid_res || got.weekday !== want.weekday ||
            got.iso_week !== want.iso_week || got.year_day !== want.year_day ||
            got.month_length !== want.month_length || got.leap !== want.leap) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("expected valid_res=%0d wday=%0d week=%0d yday=%0d mlen=%0d leap=%0d",
                     want.valid_res, want.weekday, want.iso_week, want.year_day,
                     want.month_length, want.leap);
            $display("actual   valid_res=%0d wday=%0d week=%0d yday=%0d mlen=%0d leap=%0d",
                     got.valid_res, got.weekday, got.iso_week, got.year_day,
                     got.month_length, got.leap);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked dates: field extremes, saturated years, invalid months and
  // days, leap days, and the dates where the ISO week wraps across years.
  task automatic test_directed_dates();
    send_date(12'd2000, MONTH_JAN, 5'd1);    // Week 52 of 1999.
    send_date(12'd2099, MONTH_DEC, 5'd31);   // Last supported day.
    send_date(12'd0,    4'd6,      5'd15);   // Year below range saturates up.
    send_date(12'hFFF,  4'd6,      5'd15);   // Year above range saturates down.
    send_date(12'd1999, MONTH_JAN, 5'd1);
    send_date(12'd2100, MONTH_FEB, 5'd29);   // Saturates to a common year.
    send_date(12'd2000, MONTH_FEB, 5'd29);   // Century leap year.
    send_date(12'd2001, MONTH_FEB, 5'd29);   // Not a leap year.
    send_date(12'd2024, MONTH_FEB, 5'd29);
    send_date(12'd2024, MONTH_DEC, 5'd31);   // Week 1 of the next year.
    send_date(12'd2008, MONTH_DEC, 5'd31);   // Wednesday, week 1 of 2009.
    send_date(12'd2020, MONTH_DEC, 5'd31);   // 53rd week.
    send_date(12'd2021, MONTH_JAN, 5'd1);    // Still in week 53 of 2020.
    send_date(12'd2005, MONTH_JAN, 5'd1);    // Week 53 of 2004.
    send_date(12'd2010, MONTH_JAN, 5'd3);    // Sunday before week one.
    send_date(12'd2000, 4'd0,      5'd10);   // Month zero.
    send_date(12'd2050, 4'd13,     5'd5);    // Month past December.
    send_date(12'd2023, 4'd15,     5'd31);   // Largest month code.
    send_date(12'd2050, 4'd6,      5'd0);    // Day zero.
    send_date(12'd2050, 4'd4,      5'd31);   // Past a 30-day month.
    send_date(12'd2050, 4'd7,      5'd31);   // Largest day code, valid.
    send_date(12'd2077, MONTH_MAR, 5'd1);    // Day after February.
  endtask

  // Mostly well-formed dates in the supported century, a share crowded
  // around New Year where the week numbering wraps, the rest raw field noise.
  task automatic test_random_dates(input int count);
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    int                 pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        y = YEAR_W'($urandom_range(4095));
        m = MONTH_W'($urandom_range(15));
        d = DAY_W'($urandom_range(31));
      end else begin
        y = YEAR_W'($urandom_range(int'(YEAR_MAX), int'(YEAR_MIN)));
        if (pick < 35) begin
          if ($urandom_range(1) == 1) begin
            m = MONTH_DEC;
            d = DAY_W'($urandom_range(31, 25));
          end else begin
            m = MONTH_JAN;
            d = DAY_W'($urandom_range(7, 1));
          end
        end else begin
          m = MONTH_W'($urandom_range(12, 1));
          d = DAY_W'($urandom_range(month_span(int'(y), int'(m)), 1));
        end
      end
      send_date(y, m, d);
    end
  endtask

  // A long stretch where requests go back to back and results are taken at
  // once, so the pipeline runs at its full rate.
  task automatic test_back_to_back(input int count);
    quiet = 1'b1;
    test_random_dates(count);
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long time while requests keep coming, so
  // every stage fills and the request channel has to stall.
  task automatic test_result_hold_off(input int count);
    hold_requests++;
    quiet = 1'b1;
    test_random_dates(count);
    quiet = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.year  = '0;
    req_ch.month = '0;
    req_ch.day   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_dates();
    test_random_dates(1000);
    test_back_to_back(300);
    test_result_hold_off(60);
    test_random_dates(150);
    req_ch.valid <= 1'b0;

    // Let every outstanding request come back, then wait out the drain period
    // so that a stray extra result would still be seen.
    while (pending_facts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && pending_facts.size() == 0)
      $display("iso_week_date_calculator_unit: match");
    else
      $display("iso_week_date_calculator_unit: mismatch");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("iso_week_date_calculator_unit: mismatch");
    $finish;
  end

endmodule
